// File: rtl/bts_pkg.sv
// Package for the breakpoint table sampler: operation, kind, status and mode
// codes, the stored entry layout and the control and status bundles.
// Has no dependencies.
`default_nettype none

package bts_pkg;

  localparam int TABLE_DEPTH_DEF = 256;

  localparam int IN_DATA_W  = 64;
  localparam int IN_USER_W  = 5;
  localparam int OUT_DATA_W = 160;
  localparam int OUT_USER_W = 4;

  localparam logic [1:0] FUNC_APPEND = 2'd0;
  localparam logic [1:0] FUNC_SAMPLE = 2'd1;
  localparam logic [1:0] FUNC_CLEAR  = 2'd2;

  localparam logic [1:0] KIND_PLAIN  = 2'd0;
  localparam logic [1:0] KIND_BEGIN  = 2'd1;
  localparam logic [1:0] KIND_INTERP = 2'd2;

  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_REJECT = 2'd1;
  localparam logic [1:0] STAT_FULL   = 2'd2;

  localparam logic [1:0] MODE_CONST  = 2'd0;
  localparam logic [1:0] MODE_INTERP = 2'd1;
  localparam logic [1:0] MODE_TRANS  = 2'd2;

  typedef struct packed {
    logic [31:0] pos;
    logic [31:0] value;
    logic [31:0] prior;
    logic [1:0]  kind;
  } bts_entry_t;

  typedef struct packed {
    logic accept;
    logic srch;
    logic rd_p;
    logic rd_n;
    logic cap_n;
    logic load_out;
  } bts_cmd_t;

  typedef struct packed {
    logic start_search;
    logic srch_end;
    logic lo_zero;
    logic out_free;
  } bts_stat_t;

endpackage

`default_nettype wire

// File: rtl/breakpoint_table_sampler_unit.sv
// Breakpoint table sampler. An append, clear or unused operation goes from acceptance
// straight to loading its result. A sample first runs a binary search of at most
// ceil(log2(count + 1)) probes (9 at depth 256), then reads the entries before and at
// the found place (skipped for a query before the first entry). An empty table answers
// as an append. A stalled sink holds off input until each result is loaded.
// Synchronous reset empties the table through its event count; no clearing pass.
`default_nettype none

module breakpoint_table_sampler_unit
  import bts_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_wr_en,
  input  wire logic [31:0]           cfg_wr_data,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // distance [31:0], new_value [63:32]
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  // func [1:0], value present flag [2], kind_flag [4:3]
  input  wire logic [IN_USER_W-1:0]  s_axis_tuser,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // sampled_value [31:0], segment start distance [63:32], end distance [95:64],
  // start value [127:96], end value [159:128]
  output logic [OUT_DATA_W-1:0]      m_axis_tdata,
  // status [1:0], mode [3:2]
  output logic [OUT_USER_W-1:0]      m_axis_tuser
);

  bts_cmd_t  cmd;
  bts_stat_t stat;

  bts_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .stat          (stat),
    .cmd           (cmd)
  );

  bts_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cmd           (cmd),
    .stat          (stat)
  );

endmodule

`default_nettype wire

// File: rtl/bts_ctrl.sv
// Controller state machine of the breakpoint table sampler.
// Depends on bts_pkg; drives bts_datapath through bts_cmd_t.
`default_nettype none

module bts_ctrl
  import bts_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      s_axis_tvalid,
  output logic           s_axis_tready,
  input  wire bts_stat_t stat,
  output bts_cmd_t       cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SRCH  = 3'd1;
  localparam logic [2:0] S_RD_P  = 3'd2;
  localparam logic [2:0] S_RD_N  = 3'd3;
  localparam logic [2:0] S_CAP_N = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  assign s_axis_tready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          cmd.accept = 1'b1;
          state_next = stat.start_search ? S_SRCH : S_DONE;
        end
      end
      S_SRCH: begin
        cmd.srch = 1'b1;
        if (stat.srch_end) begin
          state_next = S_RD_P;
        end
      end
      S_RD_P: begin
        cmd.rd_p   = 1'b1;
        state_next = stat.lo_zero ? S_DONE : S_RD_N;
      end
      S_RD_N: begin
        cmd.rd_n   = 1'b1;
        state_next = S_CAP_N;
      end
      S_CAP_N: begin
        cmd.cap_n  = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_done_leaves: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && stat.out_free) |=> state == S_IDLE)
    else $error("result loaded but controller did not return to idle");

  a_search_ends: assert property (@(posedge clk) disable iff (rst)
    (state == S_SRCH && stat.srch_end) |=> state == S_RD_P)
    else $error("search finished without fetching the found entry");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !cmd.accept)
    else $error("transaction accepted while busy");

endmodule

`default_nettype wire

// File: rtl/bts_datapath.sv
// Datapath of the breakpoint table sampler: event table memory, running
// value, search registers and the output register.
// Depends on bts_pkg; commanded by bts_ctrl.
`default_nettype none

module bts_datapath
  import bts_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_wr_en,
  input  wire logic [31:0]           cfg_wr_data,
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  input  wire logic [IN_USER_W-1:0]  s_axis_tuser,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0]      m_axis_tdata,
  output logic [OUT_USER_W-1:0]      m_axis_tuser,
  input  wire bts_cmd_t              cmd,
  output bts_stat_t                  stat
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  bts_entry_t mem [TABLE_DEPTH];
  bts_entry_t rd_q;
  bts_entry_t wr_entry;
  logic [AW-1:0] rd_addr;
  logic          wr_en;

  logic [1:0]  in_func;
  logic        in_val_present;
  logic [1:0]  in_kind_flag;
  logic [31:0] in_distance;
  logic [31:0] in_new_value;
  logic [1:0]  kind_sel;
  logic        reject;
  logic        full;

  logic [CW-1:0] count;
  logic [31:0]   running_value;
  logic [31:0]   initial_value;
  logic [31:0]   query;
  logic [1:0]    func_r;
  logic [1:0]    status_r;
  logic [CW-1:0] lo;
  logic [CW-1:0] len;
  logic [CW-1:0] half;
  logic [CW-1:0] mid_full;
  logic [CW-1:0] lo_next;
  logic [CW-1:0] len_next;
  logic [CW-1:0] srch_addr;
  logic [CW-1:0] lo_dec;
  logic [CW-1:0] start_addr;
  logic          go_right;

  logic [31:0] p_dist;
  logic [31:0] p_value;
  logic [31:0] p_prior;
  logic [1:0]  p_kind;
  logic [31:0] n_dist;
  logic [31:0] n_value;
  logic [1:0]  n_kind;

  logic        p_valid;
  logic        has_next;
  logic [1:0]  res_mode;
  logic [31:0] res_sampled;
  logic [31:0] res_from_dist;
  logic [31:0] res_to_dist;
  logic [31:0] res_from_val;
  logic [31:0] res_to_val;

  assign in_func        = s_axis_tuser[1:0];
  assign in_val_present = s_axis_tuser[2];
  assign in_kind_flag   = s_axis_tuser[4:3];
  assign in_distance    = s_axis_tdata[31:0];
  assign in_new_value   = s_axis_tdata[63:32];

  assign kind_sel = (in_kind_flag == KIND_BEGIN || in_kind_flag == KIND_INTERP) ?
                    in_kind_flag : KIND_PLAIN;
  assign reject   = !in_val_present && (kind_sel == KIND_PLAIN);
  assign full     = (count == CW'(TABLE_DEPTH));
  assign wr_en    = cmd.accept && (in_func == FUNC_APPEND) && !reject && !full;

  assign wr_entry.pos   = in_distance;
  assign wr_entry.prior = running_value;
  assign wr_entry.value = in_val_present ? in_new_value : running_value;
  assign wr_entry.kind  = kind_sel;

  // One probe per cycle: the entry at the current midpoint is compared and
  // the next midpoint is addressed in the same cycle.
  assign half      = len >> 1;
  assign mid_full  = lo + half;
  assign go_right  = !($signed(query) < $signed(rd_q.pos));
  assign lo_next   = go_right ? (mid_full + CW'(1)) : lo;
  assign len_next  = go_right ? (len - half - CW'(1)) : half;
  assign srch_addr = lo_next + (len_next >> 1);
  assign lo_dec    = lo - CW'(1);
  assign start_addr = count >> 1;

  always_comb begin
    if (cmd.accept) begin
      rd_addr = start_addr[AW-1:0];
    end else if (cmd.srch) begin
      rd_addr = srch_addr[AW-1:0];
    end else if (cmd.rd_p) begin
      rd_addr = lo_dec[AW-1:0];
    end else begin
      rd_addr = lo[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[count[AW-1:0]] <= wr_entry;
    end
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count         <= '0;
      running_value <= '0;
      initial_value <= '0;
    end else begin
      if (cfg_wr_en) begin
        initial_value <= cfg_wr_data;
      end
      if (wr_en) begin
        count <= count + CW'(1);
        if (in_val_present) begin
          running_value <= in_new_value;
        end
      end else if (cmd.accept && in_func == FUNC_CLEAR) begin
        count         <= '0;
        running_value <= initial_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      query  <= in_distance;
      func_r <= in_func;
      lo     <= '0;
      len    <= count;
      if (in_func == FUNC_APPEND && reject) begin
        status_r <= STAT_REJECT;
      end else if (in_func == FUNC_APPEND && full) begin
        status_r <= STAT_FULL;
      end else begin
        status_r <= STAT_OK;
      end
    end else if (cmd.srch) begin
      lo  <= lo_next;
      len <= len_next;
    end
    if (cmd.rd_n) begin
      p_dist  <= rd_q.pos;
      p_value <= rd_q.value;
      p_prior <= rd_q.prior;
      p_kind  <= rd_q.kind;
    end
    if (cmd.cap_n) begin
      n_dist  <= rd_q.pos;
      n_value <= rd_q.value;
      n_kind  <= rd_q.kind;
    end
  end

  assign p_valid  = (func_r == FUNC_SAMPLE) && (lo != '0);
  assign has_next = (lo < count);

  always_comb begin
    res_mode      = MODE_CONST;
    res_sampled   = '0;
    res_from_dist = '0;
    res_to_dist   = '0;
    res_from_val  = '0;
    res_to_val    = '0;
    if (p_valid) begin
      res_sampled   = p_value;
      res_from_dist = p_dist;
      res_to_dist   = p_dist;
      res_from_val  = p_value;
      res_to_val    = p_value;
      if (has_next && n_kind == KIND_INTERP) begin
        res_mode    = MODE_INTERP;
        res_to_dist = n_dist;
        res_to_val  = n_value;
      end else if (has_next && p_kind == KIND_BEGIN && n_kind != KIND_BEGIN) begin
        res_mode     = MODE_TRANS;
        res_to_dist  = n_dist;
        res_from_val = p_prior;
        res_to_val   = n_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (cmd.load_out) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      m_axis_tuser <= {res_mode, status_r};
      m_axis_tdata <= {res_to_val, res_from_val, res_to_dist, res_from_dist, res_sampled};
    end
  end

  assign stat.start_search = (in_func == FUNC_SAMPLE) && (count != '0);
  assign stat.srch_end     = (len_next == '0);
  assign stat.lo_zero      = (lo == '0);
  assign stat.out_free     = !m_axis_tvalid || m_axis_tready;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(TABLE_DEPTH))
    else $error("event count beyond table depth");

  a_probe_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.srch |-> len != '0)
    else $error("search probe on an empty range");

  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> m_axis_tvalid)
    else $error("loaded result not presented");

endmodule

`default_nettype wire

// File: verif/breakpoint_table_sampler_unit_test.sv
// Self-checking bench for breakpoint_table_sampler_unit: a queue-fed stream driver,
// a sink that stalls on its own pattern, and a bench-side model of the breakpoint table.
// Depends on bts_pkg and the unit RTL only.
`default_nettype none

module breakpoint_table_sampler_unit_test;
  import bts_pkg::*;

  localparam int TBL_DEPTH = TABLE_DEPTH_DEF;
  localparam int HOLD_CYCLES = 400;
  localparam int RUN_LIMIT = 5000000;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] pos;
    logic        val_present;
    logic [31:0] new_value;
    logic [1:0]  kind;
    logic        drain_first;
  } bp_op_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [1:0]  mode;
    logic [31:0] sampled;
    logic [31:0] from_d;
    logic [31:0] to_d;
    logic [31:0] from_v;
    logic [31:0] to_v;
  } bp_answer_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_wr_en = 1'b0;
  logic [31:0]           cfg_wr_data = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  // distance [31:0], new_value [63:32]
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  // func [1:0], value present flag [2], kind_flag [4:3]
  logic [IN_USER_W-1:0]  s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // sampled_value [31:0], segment start distance [63:32], end distance [95:64],
  // start value [127:96], end value [159:128]
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  // status [1:0], mode [3:2]
  logic [OUT_USER_W-1:0] m_axis_tuser;

  breakpoint_table_sampler_unit DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #6 clk = ~clk;

  // Bench copy of the breakpoint table and its running value.
  logic [31:0] tbl_dist  [TBL_DEPTH];
  logic [31:0] tbl_value [TBL_DEPTH];
  logic [31:0] tbl_prior [TBL_DEPTH];
  logic [1:0]  tbl_kind  [TBL_DEPTH];
  int          tbl_count = 0;
  logic [31:0] running_value = '0;
  logic [31:0] init_value = '0;

  bp_op_t      pending_ops[$];
  bp_answer_t  lookup_answers[$];
  bp_op_t      offered;
  int          issued = 0;
  int          accepted = 0;
  int          results_seen = 0;
  int          mismatches = 0;
  logic        hold_for_drain = 1'b0;
  int          hold_requests = 0;

  int n_append = 0, n_reject = 0, n_full = 0, n_clear = 0, n_other = 0, n_settings = 0;
  int n_mode[3] = '{0, 0, 0};

  function automatic logic rnd_bit();
    return 1'($urandom);
  endfunction

  function automatic logic [1:0] rnd_kind();
    return 2'($urandom);
  endfunction

  function automatic bp_answer_t apply_to_table(bp_op_t op);
    bp_answer_t r;
    logic [1:0] k;
    int lo, len, half, mid, p, nx;
    r = '0;
    case (op.func)
      FUNC_APPEND: begin
        k = (op.kind == KIND_BEGIN || op.kind == KIND_INTERP) ? op.kind : KIND_PLAIN;
        if (!op.val_present && k == KIND_PLAIN) begin
          r.status = STAT_REJECT;
          n_reject++;
        end else if (tbl_count >= TBL_DEPTH) begin
          r.status = STAT_FULL;
          n_full++;
        end else begin
          tbl_dist[tbl_count] = op.pos;
          tbl_prior[tbl_count] = running_value;
          if (op.val_present) running_value = op.new_value;
          tbl_value[tbl_count] = running_value;
          tbl_kind[tbl_count] = k;
          tbl_count++;
          n_append++;
        end
      end
      FUNC_SAMPLE: begin
        lo = 0;
        len = tbl_count;
        while (len > 0) begin
          half = len / 2;
          mid = lo + half;
          if (!($signed(op.pos) < $signed(tbl_dist[mid]))) begin
            lo = mid + 1;
            len = len - half - 1;
          end else begin
            len = half;
          end
        end
        nx = lo;
        if (nx > 0) begin
          p = nx - 1;
          r.mode = MODE_CONST;
          r.sampled = tbl_value[p];
          r.from_d = tbl_dist[p];
          r.to_d = tbl_dist[p];
          r.from_v = tbl_value[p];
          r.to_v = tbl_value[p];
          if (nx < tbl_count && tbl_kind[nx] == KIND_INTERP) begin
            r.mode = MODE_INTERP;
            r.to_d = tbl_dist[nx];
            r.to_v = tbl_value[nx];
          end else if (nx < tbl_count && tbl_kind[p] == KIND_BEGIN &&
                       tbl_kind[nx] != KIND_BEGIN) begin
            r.mode = MODE_TRANS;
            r.to_d = tbl_dist[nx];
            r.from_v = tbl_prior[p];
            r.to_v = tbl_value[nx];
          end
        end
        n_mode[r.mode]++;
      end
      FUNC_CLEAR: begin
        tbl_count = 0;
        running_value = init_value;
        n_clear++;
      end
      default: begin
        n_other++;
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    mismatches++;
    if (mismatches <= 40)
      $display("mismatch in %s at result %0d: got %h, expected %h",
               field, results_seen, got, want);
  endtask

  task automatic push_op(logic [1:0] func, logic [31:0] pos, logic hv, logic [31:0] val,
                         logic [1:0] kind);
    bp_op_t op;
    op.func = func;
    op.pos = pos;
    op.val_present = hv;
    op.new_value = val;
    op.kind = kind;
    op.drain_first = hold_for_drain || ($urandom_range(0, 79) == 0);
    hold_for_drain = 1'b0;
    pending_ops.insert(pending_ops.size(), op);
    issued++;
  endtask

  function automatic logic [31:0] clip_dist(longint d);
    if (d > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (d < -64'sd2147483648) return 32'h8000_0000;
    return d[31:0];
  endfunction

  // Waits until every transaction has been answered, lets the block settle,
  // then writes the initial value register.
  task automatic settle_and_configure(logic [31:0] v);
    while (accepted != issued || lookup_answers.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    init_value = v;
    n_settings++;
  endtask

  // One run: usually a clear, then mostly sorted appends with samples mixed in,
  // with some noise, rejected appends and out-of-order appends.
  task automatic random_run();
    logic [31:0] dists[$];
    longint cur, t;
    int n_steps, r;
    logic hv;
    if ($urandom_range(0, 5) != 0)
      push_op(FUNC_CLEAR, $urandom, rnd_bit(), $urandom, rnd_kind());
    case ($urandom_range(0, 7))
      0: cur = -64'sd2147483648;
      1: cur = 64'sd2147483647 - longint'($urandom_range(0, 3000));
      2: cur = longint'($signed($urandom));
      default: cur = longint'($urandom_range(0, 20000)) - 10000;
    endcase
    n_steps = ($urandom_range(0, 7) == 0) ? $urandom_range(26, 120) : $urandom_range(2, 24);
    for (int i = 0; i < n_steps; i++) begin
      r = $urandom_range(0, 99);
      if (r < 4) begin
        push_op(2'd3, $urandom, rnd_bit(), $urandom, rnd_kind());
      end else if (r < 9) begin
        push_op(FUNC_APPEND, $urandom, 1'b0, $urandom, ($urandom_range(0, 1) != 0) ? 2'd3
                : KIND_PLAIN);
      end else if (r < 13) begin
        push_op(FUNC_APPEND, $urandom, 1'b1, $urandom, rnd_kind());
      end else if (r < 45 && dists.size() != 0) begin
        t = longint'($signed(dists[$urandom_range(0, dists.size() - 1)]));
        if ($urandom_range(0, 2) != 0) t = t + longint'($urandom_range(0, 600)) - 300;
        push_op(FUNC_SAMPLE, clip_dist(t), rnd_bit(), $urandom, rnd_kind());
      end else begin
        if ($urandom_range(0, 9) == 0) cur = cur + longint'($urandom_range(0, 32'h00FF_FFFF));
        else if ($urandom_range(0, 4) != 0) cur = cur + longint'($urandom_range(1, 700));
        if (cur > 64'sd2147483647) cur = 64'sd2147483647;
        hv = ($urandom_range(0, 3) != 0);
        push_op(FUNC_APPEND, cur[31:0], hv, $urandom,
                hv ? 2'($urandom_range(0, 3)) : 2'($urandom_range(1, 2)));
        dists.insert(dists.size(), cur[31:0]);
      end
    end
    push_op(FUNC_SAMPLE, $urandom, rnd_bit(), $urandom, rnd_kind());
    for (int i = $urandom_range(1, 5); i > 0; i--) begin
      t = (dists.size() != 0) ? longint'($signed(dists[$urandom_range(0, dists.size() - 1)]))
          : 0;
      push_op(FUNC_SAMPLE, clip_dist(t + longint'($urandom_range(0, 400)) - 200),
              rnd_bit(), $urandom, rnd_kind());
    end
  endtask

  always @(posedge clk) begin : op_driver
    static int burst_left = 0;
    static int gap_left = 0;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        lookup_answers.insert(lookup_answers.size(), apply_to_table(offered));
        accepted++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_ops.size() != 0 &&
                     !(pending_ops[0].drain_first && lookup_answers.size() != 0)) begin
          offered = pending_ops.pop_front();
          s_axis_tdata <= {offered.new_value, offered.pos};
          s_axis_tuser <= {offered.kind, offered.val_present, offered.func};
          s_axis_tvalid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : sink_pattern
    static int pat_kind = 0;
    static int pat_left = 0;
    static int pat_phase = 0;
    static int hold_left = 0;
    static int hold_seen = 0;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (hold_seen != hold_requests) begin
        hold_seen = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (pat_left == 0) begin
        pat_kind = $urandom_range(0, 3);
        pat_left = $urandom_range(8, 120);
      end else begin
        pat_left--;
      end
      pat_phase++;
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        case (pat_kind)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= ($urandom_range(0, 1) != 0);
          2: m_axis_tready <= ($urandom_range(0, 7) == 0);
          default: m_axis_tready <= (pat_phase % 3 != 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin : result_check
    bp_answer_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (lookup_answers.size() == 0) begin
        report_mismatch("result with nothing pending", m_axis_tdata[31:0], '0);
      end else begin
        want = lookup_answers.pop_front();
        if (m_axis_tuser[1:0] !== want.status)
          report_mismatch("status", 32'(m_axis_tuser[1:0]), 32'(want.status));
        if (m_axis_tuser[3:2] !== want.mode)
          report_mismatch("mode", 32'(m_axis_tuser[3:2]), 32'(want.mode));
        if (m_axis_tdata[31:0] !== want.sampled)
          report_mismatch("sampled_value", m_axis_tdata[31:0], want.sampled);
        if (m_axis_tdata[63:32] !== want.from_d)
          report_mismatch("start distance", m_axis_tdata[63:32], want.from_d);
        if (m_axis_tdata[95:64] !== want.to_d)
          report_mismatch("end distance", m_axis_tdata[95:64], want.to_d);
        if (m_axis_tdata[127:96] !== want.from_v)
          report_mismatch("start value", m_axis_tdata[127:96], want.from_v);
        if (m_axis_tdata[159:128] !== want.to_v)
          report_mismatch("end value", m_axis_tdata[159:128], want.to_v);
      end
    end
  end

  initial begin : watchdog
    #(RUN_LIMIT);
    $display("TB_ERROR");
    $finish;
  end

  initial begin : stimulus
    int target;
    logic hv;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed part: empty table, rejections, extremes and every segment mode.
    settle_and_configure(32'h7FFF_FFFF);
    push_op(FUNC_SAMPLE, 32'h0000_0000, 1'b1, 32'hFFFF_FFFF, KIND_INTERP);
    push_op(FUNC_APPEND, 32'h0000_0100, 1'b0, 32'h1234_5678, KIND_PLAIN);
    push_op(FUNC_APPEND, 32'h0000_0100, 1'b0, 32'h1234_5678, 2'd3);
    push_op(FUNC_CLEAR, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 2'd3);
    push_op(FUNC_APPEND, 32'h8000_0000, 1'b0, 32'hFFFF_FFFF, KIND_BEGIN);
    push_op(FUNC_APPEND, 32'hFFFF_FF00, 1'b1, 32'h8000_0000, KIND_PLAIN);
    push_op(FUNC_APPEND, 32'h0000_0000, 1'b1, 32'h7FFF_FFFF, KIND_INTERP);
    push_op(FUNC_APPEND, 32'h0000_0100, 1'b1, 32'h1234_5678, 2'd3);
    push_op(FUNC_APPEND, 32'h0000_0100, 1'b0, 32'h0000_0000, KIND_BEGIN);
    push_op(FUNC_APPEND, 32'h0000_0200, 1'b0, 32'h0000_0000, KIND_BEGIN);
    push_op(FUNC_APPEND, 32'h7FFF_FFFF, 1'b1, 32'hFFFF_FFFF, KIND_INTERP);
    push_op(2'd3, 32'hA5A5_5A5A, 1'b1, 32'h5A5A_A5A5, 2'd3);
    push_op(FUNC_SAMPLE, 32'h8000_0000, 1'b0, 32'h0, KIND_PLAIN);
    push_op(FUNC_SAMPLE, 32'hFFFF_FEFF, 1'b0, 32'h0, KIND_PLAIN);
    push_op(FUNC_SAMPLE, 32'hFFFF_FFFF, 1'b1, 32'h0, KIND_BEGIN);
    push_op(FUNC_SAMPLE, 32'h0000_0000, 1'b0, 32'h0, KIND_PLAIN);
    push_op(FUNC_SAMPLE, 32'h0000_0080, 1'b0, 32'h0, KIND_PLAIN);
    push_op(FUNC_SAMPLE, 32'h0000_0100, 1'b0, 32'h0, KIND_PLAIN);
    push_op(FUNC_SAMPLE, 32'h0000_0180, 1'b0, 32'h0, KIND_PLAIN);
    push_op(FUNC_SAMPLE, 32'h7FFF_FFFE, 1'b0, 32'h0, KIND_PLAIN);
    push_op(FUNC_SAMPLE, 32'h7FFF_FFFF, 1'b0, 32'h0, KIND_PLAIN);
    push_op(FUNC_APPEND, 32'h0000_0000, 1'b1, 32'h0000_0001, KIND_PLAIN);
    push_op(FUNC_SAMPLE, 32'h0000_0000, 1'b0, 32'h0, KIND_PLAIN);

    // Fill the table to its depth, then try appends on a full table.
    settle_and_configure(32'h8000_0000);
    push_op(FUNC_CLEAR, $urandom, rnd_bit(), $urandom, rnd_kind());
    for (int i = 0; i < TBL_DEPTH; i++) begin
      hv = 1'($urandom_range(0, 1));
      push_op(FUNC_APPEND, -40000 + i * 300 + ($urandom_range(0, 2) == 0 ? 0 : 150), hv,
              $urandom, hv ? 2'($urandom_range(0, 3)) : 2'($urandom_range(1, 2)));
    end
    push_op(FUNC_APPEND, 32'h7FFF_FFFF, 1'b1, $urandom, KIND_PLAIN);
    push_op(FUNC_APPEND, 32'h7FFF_FFFF, 1'b0, $urandom, KIND_PLAIN);
    push_op(FUNC_APPEND, 32'h7FFF_FFFF, 1'b0, $urandom, KIND_BEGIN);
    hold_for_drain = 1'b1;
    push_op(FUNC_SAMPLE, 32'h8000_0000, rnd_bit(), $urandom, rnd_kind());
    push_op(FUNC_SAMPLE, 32'h7FFF_FFFF, rnd_bit(), $urandom, rnd_kind());
    for (int i = 0; i < 12; i++)
      push_op(FUNC_SAMPLE, -40100 + $urandom_range(0, 77000), rnd_bit(), $urandom,
              rnd_kind());

    // Random runs under several settings; the sink holds off once while
    // the driver keeps offering.
    settle_and_configure($urandom);
    target = issued + 140;
    while (issued < target) random_run();
    hold_requests++;
    settle_and_configure(32'hFFFF_FFFF);
    target = issued + 140;
    while (issued < target) random_run();
    settle_and_configure(32'h0000_0000);
    target = issued + 140;
    while (issued < target) random_run();

    while (accepted != issued || lookup_answers.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    $display("covered %0d transactions over %0d initial value settings:",
             accepted, n_settings);
    $display("%0d appends stored, %0d rejected, %0d on a full table, %0d clears, %0d unused",
             n_append, n_reject, n_full, n_clear, n_other);
    $display("samples by segment: %0d constant, %0d interpolate, %0d transition",
             n_mode[MODE_CONST], n_mode[MODE_INTERP], n_mode[MODE_TRANS]);
    if (mismatches == 0 && lookup_answers.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: breakpoint_table_sampler_unit.f
rtl/bts_pkg.sv
rtl/bts_ctrl.sv
rtl/bts_datapath.sv
rtl/breakpoint_table_sampler_unit.sv
verif/breakpoint_table_sampler_unit_test.sv
